// ----- hdl/gstp_pkg.sv -----
// shared types, constants and size tables for the sprite tile packer
`timescale 1ns / 1ps
package gstp_pkg;

   localparam int NumSizes       = 12;
   localparam int SizeIdxW       = 4;
   localparam int RowStride      = 8;
   localparam int MaxColsDefault = 8;
   localparam int MaxRowsDefault = 8;
   localparam int CntW           = 7;
   localparam int DensW          = 17;
   localparam int AreaW          = 7;
   localparam int CoordW         = 3;
   localparam int DimW           = 4;
   localparam int TileW          = 10;
   localparam int UsedW          = 13;
   localparam int DensScale      = 1000;
   localparam int TileLimit      = 1024;
   localparam logic [TileW-1:0] TileMax = 10'd1023;

   typedef enum logic [1:0] {
      REG_GRID_COLS = 2'd0,
      REG_GRID_ROWS = 2'd1,
      REG_TILE_BASE = 2'd2,
      REG_PACK_MODE = 2'd3
   } reg_idx_type;

   localparam logic [1:0] StatusOk    = 2'd0;
   localparam logic [1:0] StatusRange = 2'd1;
   localparam logic [1:0] StatusNone  = 2'd2;

   typedef struct packed {
      logic              found;
      logic [CntW-1:0]   cnt;
      logic [DensW-1:0]  dens;
      logic [AreaW-1:0]  area;
      logic [CoordW-1:0] y;
      logic [CoordW-1:0] x;
   } cand_type;

   // width in tiles, largest sizes first
   function automatic logic [DimW-1:0] size_w(logic [SizeIdxW-1:0] d);
      case (d)
         4'd0, 4'd1:                      return 4'd8;
         4'd2, 4'd3, 4'd4, 4'd6:          return 4'd4;
         4'd5, 4'd7, 4'd9:                return 4'd2;
         default:                         return 4'd1;
      endcase
   endfunction

   function automatic logic [DimW-1:0] size_h(logic [SizeIdxW-1:0] d);
      case (d)
         4'd0, 4'd2:                      return 4'd8;
         4'd1, 4'd3, 4'd5, 4'd8:          return 4'd4;
         4'd4, 4'd7, 4'd10:               return 4'd2;
         default:                         return 4'd1;
      endcase
   endfunction

   function automatic logic [1:0] size_shape(logic [SizeIdxW-1:0] d);
      case (d)
         4'd0, 4'd3, 4'd7, 4'd11:         return 2'd0;
         4'd1, 4'd4, 4'd6, 4'd9:          return 2'd1;
         default:                         return 2'd2;
      endcase
   endfunction

   function automatic logic [1:0] size_class(logic [SizeIdxW-1:0] d);
      case (d)
         4'd0, 4'd1, 4'd2:                return 2'd3;
         4'd3, 4'd4, 4'd5:                return 2'd2;
         4'd6, 4'd7, 4'd8:                return 2'd1;
         default:                         return 2'd0;
      endcase
   endfunction

   function automatic logic [AreaW-1:0] size_area(logic [SizeIdxW-1:0] d);
      case (d)
         4'd0:                            return 7'd64;
         4'd1, 4'd2:                      return 7'd32;
         4'd3:                            return 7'd16;
         4'd4, 4'd5:                      return 7'd8;
         4'd6, 4'd7, 4'd8:                return 7'd4;
         4'd9, 4'd10:                     return 7'd2;
         default:                         return 7'd1;
      endcase
   endfunction

   // 8x8 cover mask of a rectangle, row stride of eight bits
   function automatic logic [63:0] rect_mask(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                                             logic [DimW-1:0] w, logic [DimW-1:0] h);
      logic [7:0]  pat;
      logic [63:0] m;
      pat = 8'(8'((9'd1 << w) - 9'd1) << x);
      for (int r = 0; r < 8; r++) begin
         m[r*8 +: 8] = (4'(r) >= {1'b0, y} && 4'(r) < ({1'b0, y} + h)) ? pat : 8'd0;
      end
      return m;
   endfunction

   // count, then density, then area, then lower row, then lower column
   function automatic logic cand_better(cand_type a, cand_type b);
      return !b.found || a.cnt > b.cnt ||
             (a.cnt == b.cnt && (a.dens > b.dens ||
             (a.dens == b.dens && (a.area > b.area ||
             (a.area == b.area && (a.y < b.y || (a.y == b.y && a.x < b.x)))))));
   endfunction

endpackage

// ----- hdl/gstp_if.sv -----
// request and response channel interfaces of the sprite tile packer
`timescale 1ns / 1ps
interface gstp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] row_mask;
   logic       last_row;
   modport source (output valid, row_mask, last_row, input ready);
   modport sink (input valid, row_mask, last_row, output ready);
endinterface

interface gstp_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [2:0]              piece_col;
   logic [2:0]              piece_row;
   logic [1:0]              shape_code;
   logic [1:0]              size_code;
   logic [9:0]              first_tile;
   logic [1:0]              status;
   logic                    last_piece;
   modport source (output valid, piece_col, piece_row, shape_code, size_code, first_tile,
                   status, last_piece, input ready);
   modport sink (input valid, piece_col, piece_row, shape_code, size_code, first_tile,
                 status, last_piece, output ready);
endinterface

// ----- hdl/gstp_lane.sv -----
// one sprite size: walks its placements around the anchor and keeps the best
`timescale 1ns / 1ps
module gstp_lane #(
   parameter int MAX_ROWS = gstp_pkg::MaxRowsDefault,
   parameter int W        = 1,
   parameter int H        = 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    clear,
   input  logic                                    step,
   input  logic [gstp_pkg::CoordW-1:0]             seed_x,
   input  logic [gstp_pkg::CoordW-1:0]             seed_y,
   input  logic [gstp_pkg::CoordW-1:0]             off_x,
   input  logic [gstp_pkg::CoordW-1:0]             off_y,
   input  logic [gstp_pkg::DimW-1:0]               cols_eff,
   input  logic [gstp_pkg::DimW-1:0]               rows_eff,
   input  logic                                    pack_mode,
   input  logic [MAX_ROWS*gstp_pkg::RowStride-1:0] remaining,
   input  logic [MAX_ROWS*gstp_pkg::RowStride-1:0] occupied,
   output gstp_pkg::cand_type                      best
);
   localparam int MapBits = MAX_ROWS * gstp_pkg::RowStride;
   localparam int Area    = W * H;
   localparam int LogArea = $clog2(Area);
   localparam logic [gstp_pkg::DimW-1:0] WC = gstp_pkg::DimW'(W);
   localparam logic [gstp_pkg::DimW-1:0] HC = gstp_pkg::DimW'(H);

   logic [gstp_pkg::DimW-1:0]   sum_x, sum_y;
   logic [gstp_pkg::CoordW-1:0] pos_x, pos_y;
   logic                        pos_ok, hit_occ, cand_ok;
   logic [63:0]                 full_mask;
   logic [MapBits-1:0]          hits;
   logic [3:0]                  row_cnt [MAX_ROWS];
   logic [gstp_pkg::CntW-1:0]   cnt;

   logic                        a_valid_ff, a_valid_in;
   logic [gstp_pkg::CntW-1:0]   a_cnt_ff;
   logic [gstp_pkg::CoordW-1:0] a_x_ff, a_y_ff;
   gstp_pkg::cand_type          cand, best_ff, best_in;

   // placement = anchor + offset - (size - 1), kept in unsigned form
   always_comb begin
      sum_x  = {1'b0, seed_x} + {1'b0, off_x};
      sum_y  = {1'b0, seed_y} + {1'b0, off_y};
      pos_ok = ({1'b0, off_x} < WC) && ({1'b0, off_y} < HC) &&
               (sum_x >= WC - 4'd1) && (sum_y >= HC - 4'd1) &&
               (sum_x < cols_eff) && (sum_y < rows_eff);
      pos_x  = gstp_pkg::CoordW'(sum_x - (WC - 4'd1));
      pos_y  = gstp_pkg::CoordW'(sum_y - (HC - 4'd1));
      full_mask = gstp_pkg::rect_mask(pos_x, pos_y, WC, HC);
      hits    = remaining & full_mask[MapBits-1:0];
      hit_occ = |(occupied & full_mask[MapBits-1:0]);
      for (int r = 0; r < MAX_ROWS; r++) begin
         row_cnt[r] = 4'd0;
         for (int c = 0; c < gstp_pkg::RowStride; c++) begin
            row_cnt[r] = row_cnt[r] + 4'(hits[r*gstp_pkg::RowStride + c]);
         end
      end
      cnt = '0;
      for (int r = 0; r < MAX_ROWS; r++) begin
         cnt = cnt + gstp_pkg::CntW'(row_cnt[r]);
      end
      cand_ok = pos_ok && !(pack_mode && hit_occ) && (cnt != '0) &&
                ((Area == 1) || (cnt >= 7'd2 && {cnt, 1'b0} >= 8'(Area)));
      a_valid_in = step && cand_ok && !clear;
   end

   // density against the held best
   always_comb begin
      cand.found = 1'b1;
      cand.cnt   = a_cnt_ff;
      cand.dens  = gstp_pkg::DensW'((gstp_pkg::DensW'(a_cnt_ff) *
                   gstp_pkg::DensW'(gstp_pkg::DensScale)) >> LogArea);
      cand.area  = gstp_pkg::AreaW'(Area);
      cand.y     = a_y_ff;
      cand.x     = a_x_ff;
      best_in    = best_ff;
      if (clear) begin
         best_in.found = 1'b0;
      end else if (a_valid_ff && gstp_pkg::cand_better(cand, best_ff)) begin
         best_in = cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         best_ff    <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         best_ff    <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      a_cnt_ff <= cnt;
      a_x_ff   <= pos_x;
      a_y_ff   <= pos_y;
   end

   assign best = best_ff;

endmodule

// ----- hdl/gstp_merge.sv -----
// walks the lane results in table order and keeps the overall best
`timescale 1ns / 1ps
module gstp_merge (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  gstp_pkg::cand_type                lane_best [gstp_pkg::NumSizes],
   output gstp_pkg::cand_type                best,
   output logic [gstp_pkg::SizeIdxW-1:0]     best_size,
   output logic                              done
);
   localparam logic [gstp_pkg::SizeIdxW-1:0] LastIdx =
      gstp_pkg::SizeIdxW'(gstp_pkg::NumSizes - 1);

   logic                            busy_ff, busy_in;
   logic [gstp_pkg::SizeIdxW-1:0]   idx_ff, idx_in;
   logic [gstp_pkg::SizeIdxW-1:0]   size_ff, size_in;
   gstp_pkg::cand_type              best_ff, best_in, pick;

   always_comb begin
      pick    = lane_best[idx_ff];
      done    = busy_ff && (idx_ff == LastIdx);
      busy_in = busy_ff;
      idx_in  = idx_ff;
      best_in = best_ff;
      size_in = size_ff;
      if (start) begin
         busy_in       = 1'b1;
         idx_in        = '0;
         best_in.found = 1'b0;
      end else if (busy_ff) begin
         if (pick.found && gstp_pkg::cand_better(pick, best_ff)) begin
            best_in = pick;
            size_in = idx_ff;
         end
         idx_in = idx_ff + 1'b1;
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         best_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         best_ff <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
   end

   assign best      = best_ff;
   assign best_size = size_ff;

endmodule

// ----- hdl/greedy_sprite_tile_packer_unit.sv -----
// top level of the greedy sprite tile packer: row store, sequencer, lanes, merge, csr
// row requests are taken in the idle state; a request with last_row starts packing
// packing: a setup state, then for each piece the anchor state, the 64-step placement
// sweep, drain, merge of the lane results and emit, plus any stall on the response
// no request is taken while packing; up to 64 pieces per packing
// reset (synchronous): maps cleared, no rows loaded, registers at 8, 8, 0, 0
`timescale 1ns / 1ps
module greedy_sprite_tile_packer_unit #(
   parameter int MAX_COLS = gstp_pkg::MaxColsDefault,
   parameter int MAX_ROWS = gstp_pkg::MaxRowsDefault
) (
   input  logic        clock,
   input  logic        reset,
   gstp_req_if.sink    req_chan,
   gstp_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int MapBits = MAX_ROWS * gstp_pkg::RowStride;
   localparam int LoadW   = $clog2(MAX_ROWS + 1);
   localparam int Stride  = gstp_pkg::RowStride;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_PREP   = 7'b0000010,
      S_ANCHOR = 7'b0000100,
      S_SWEEP  = 7'b0001000,
      S_DRAIN  = 7'b0010000,
      S_MERGE  = 7'b0100000,
      S_EMIT   = 7'b1000000
   } state_type;

   // configuration registers
   logic [3:0] grid_cols_ff, grid_cols_in;
   logic [3:0] grid_rows_ff, grid_rows_in;
   logic [9:0] tile_base_ff, tile_base_in;
   logic       pack_mode_ff, pack_mode_in;
   logic       csr_wr;

   // packing state
   state_type                   state_ff, state_in;
   logic [MapBits-1:0]          remaining_ff, remaining_in;
   logic [MapBits-1:0]          occupied_ff, occupied_in;
   logic [gstp_pkg::UsedW-1:0]  tiles_used_ff, tiles_used_in;
   logic [LoadW-1:0]            rows_loaded_ff, rows_loaded_in;
   logic [5:0]                  pieces_ff, pieces_in;
   logic [5:0]                  sweep_ff, sweep_in;
   logic [2:0]                  seed_x_ff, seed_x_in, seed_y_ff, seed_y_in;

   // response holding register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in;
   logic [1:0] rsp_shape_ff, rsp_shape_in, rsp_size_ff, rsp_size_in;
   logic [9:0] rsp_tile_ff, rsp_tile_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic       rsp_last_ff, rsp_last_in;

   // datapath helpers
   logic [3:0]                    cols_eff, rows_eff;
   logic [MapBits-1:0]            area_mask;
   logic                          anchor_any;
   logic [5:0]                    anchor_idx;
   logic                          req_fire, out_free, lane_clear, lane_step, merge_start;
   gstp_pkg::cand_type            lane_best [gstp_pkg::NumSizes];
   gstp_pkg::cand_type            best;
   logic [gstp_pkg::SizeIdxW-1:0] best_size;
   logic                          merge_done;
   logic [3:0]                    best_w, best_h;
   logic [63:0]                   best_rect;
   logic [MapBits-1:0]            next_rem;
   logic [13:0]                   start_tile;
   logic                          piece_last;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      grid_cols_in = grid_cols_ff;
      grid_rows_in = grid_rows_ff;
      tile_base_in = tile_base_ff;
      pack_mode_in = pack_mode_ff;
      if (csr_wr) begin
         unique case (gstp_pkg::reg_idx_type'(csr_paddr[3:2]))
            gstp_pkg::REG_GRID_COLS: grid_cols_in = csr_pwdata[3:0];
            gstp_pkg::REG_GRID_ROWS: grid_rows_in = csr_pwdata[3:0];
            gstp_pkg::REG_TILE_BASE: tile_base_in = csr_pwdata[9:0];
            gstp_pkg::REG_PACK_MODE: pack_mode_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (gstp_pkg::reg_idx_type'(csr_paddr[3:2]))
         gstp_pkg::REG_GRID_COLS: csr_prdata = {28'd0, grid_cols_ff};
         gstp_pkg::REG_GRID_ROWS: csr_prdata = {28'd0, grid_rows_ff};
         gstp_pkg::REG_TILE_BASE: csr_prdata = {22'd0, tile_base_ff};
         gstp_pkg::REG_PACK_MODE: csr_prdata = {31'd0, pack_mode_ff};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   // ---------------- grid size and anchor ----------------
   always_comb begin
      // zero counts as one, oversize clamps to the build maximum
      cols_eff = (grid_cols_ff == 4'd0) ? 4'd1 :
                 (grid_cols_ff > 4'(MAX_COLS)) ? 4'(MAX_COLS) : grid_cols_ff;
      rows_eff = (grid_rows_ff == 4'd0) ? 4'd1 :
                 (grid_rows_ff > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : grid_rows_ff;
      for (int r = 0; r < MAX_ROWS; r++) begin
         for (int c = 0; c < Stride; c++) begin
            area_mask[r*Stride + c] = (4'(r) < rows_eff) && (4'(c) < cols_eff);
         end
      end
      // first remaining tile in raster order
      anchor_any = 1'b0;
      anchor_idx = 6'd0;
      for (int i = MapBits - 1; i >= 0; i--) begin
         if (remaining_ff[i]) begin
            anchor_any = 1'b1;
            anchor_idx = 6'(i);
         end
      end
   end

   // ---------------- lanes, one per sprite size ----------------
   assign lane_clear  = (state_ff == S_ANCHOR);
   assign lane_step   = (state_ff == S_SWEEP);
   assign merge_start = (state_ff == S_DRAIN);

   for (genvar d = 0; d < gstp_pkg::NumSizes; d++) begin : g_lane
      gstp_lane #(
         .MAX_ROWS (MAX_ROWS),
         .W        (int'(gstp_pkg::size_w(gstp_pkg::SizeIdxW'(d)))),
         .H        (int'(gstp_pkg::size_h(gstp_pkg::SizeIdxW'(d))))
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .clear     (lane_clear),
         .step      (lane_step),
         .seed_x    (seed_x_ff),
         .seed_y    (seed_y_ff),
         .off_x     (sweep_ff[2:0]),
         .off_y     (sweep_ff[5:3]),
         .cols_eff  (cols_eff),
         .rows_eff  (rows_eff),
         .pack_mode (pack_mode_ff),
         .remaining (remaining_ff),
         .occupied  (occupied_ff),
         .best      (lane_best[d])
      );
   end

   gstp_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .start     (merge_start),
      .lane_best (lane_best),
      .best      (best),
      .best_size (best_size),
      .done      (merge_done)
   );

   // ---------------- sequencer ----------------
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == S_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      best_w     = gstp_pkg::size_w(best_size);
      best_h     = gstp_pkg::size_h(best_size);
      best_rect  = gstp_pkg::rect_mask(best.x, best.y, best_w, best_h);
      next_rem   = remaining_ff & ~best_rect[MapBits-1:0];
      start_tile = 14'(tile_base_ff) + 14'(tiles_used_ff);
      // final piece: nothing left, the piece budget used up, or no candidate
      piece_last = !best.found || (next_rem == '0) || (pieces_ff == 6'd63);
   end

   always_comb begin
      state_in       = state_ff;
      remaining_in   = remaining_ff;
      occupied_in    = occupied_ff;
      tiles_used_in  = tiles_used_ff;
      rows_loaded_in = rows_loaded_ff;
      pieces_in      = pieces_ff;
      sweep_in       = sweep_ff;
      seed_x_in      = seed_x_ff;
      seed_y_in      = seed_y_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_col_in     = rsp_col_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_shape_in   = rsp_shape_ff;
      rsp_size_in    = rsp_size_ff;
      rsp_tile_in    = rsp_tile_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               // store the row while there is room, extra rows drop
               if (rows_loaded_ff < LoadW'(MAX_ROWS)) begin
                  for (int r = 0; r < MAX_ROWS; r++) begin
                     if (LoadW'(r) == rows_loaded_ff) begin
                        remaining_in[r*Stride +: Stride] = req_chan.row_mask;
                     end
                  end
                  rows_loaded_in = rows_loaded_ff + 1'b1;
               end
               if (req_chan.last_row) begin
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            remaining_in  = remaining_ff & area_mask;
            occupied_in   = '0;
            tiles_used_in = '0;
            pieces_in     = '0;
            state_in      = S_ANCHOR;
         end
         S_ANCHOR: begin
            if (anchor_any) begin
               seed_x_in = anchor_idx[2:0];
               seed_y_in = anchor_idx[5:3];
               sweep_in  = '0;
               state_in  = S_SWEEP;
            end else begin
               // empty grid gives no pieces
               remaining_in   = '0;
               occupied_in    = '0;
               rows_loaded_in = '0;
               state_in       = S_IDLE;
            end
         end
         S_SWEEP: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == 6'd63) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_MERGE;
         end
         S_MERGE: begin
            if (merge_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = piece_last;
               pieces_in    = pieces_ff + 1'b1;
               if (best.found) begin
                  rsp_col_in    = best.x;
                  rsp_row_in    = best.y;
                  rsp_shape_in  = gstp_pkg::size_shape(best_size);
                  rsp_size_in   = gstp_pkg::size_class(best_size);
                  rsp_tile_in   = (start_tile > 14'(gstp_pkg::TileMax)) ?
                                  gstp_pkg::TileMax : start_tile[9:0];
                  rsp_status_in = ((15'(start_tile) + 15'(best.area)) >
                                   15'(gstp_pkg::TileLimit)) ?
                                  gstp_pkg::StatusRange : gstp_pkg::StatusOk;
                  tiles_used_in = tiles_used_ff + gstp_pkg::UsedW'(best.area);
                  remaining_in  = next_rem;
                  occupied_in   = occupied_ff | best_rect[MapBits-1:0];
               end else begin
                  rsp_col_in    = '0;
                  rsp_row_in    = '0;
                  rsp_shape_in  = '0;
                  rsp_size_in   = '0;
                  rsp_tile_in   = '0;
                  rsp_status_in = gstp_pkg::StatusNone;
               end
               if (piece_last) begin
                  remaining_in   = '0;
                  occupied_in    = '0;
                  rows_loaded_in = '0;
                  state_in       = S_IDLE;
               end else begin
                  state_in = S_ANCHOR;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff   <= 4'd8;
         grid_rows_ff   <= 4'd8;
         tile_base_ff   <= '0;
         pack_mode_ff   <= 1'b0;
         state_ff       <= S_IDLE;
         remaining_ff   <= '0;
         occupied_ff    <= '0;
         tiles_used_ff  <= '0;
         rows_loaded_ff <= '0;
         pieces_ff      <= '0;
         sweep_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         grid_cols_ff   <= grid_cols_in;
         grid_rows_ff   <= grid_rows_in;
         tile_base_ff   <= tile_base_in;
         pack_mode_ff   <= pack_mode_in;
         state_ff       <= state_in;
         remaining_ff   <= remaining_in;
         occupied_ff    <= occupied_in;
         tiles_used_ff  <= tiles_used_in;
         rows_loaded_ff <= rows_loaded_in;
         pieces_ff      <= pieces_in;
         sweep_ff       <= sweep_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      seed_x_ff     <= seed_x_in;
      seed_y_ff     <= seed_y_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_shape_ff  <= rsp_shape_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_tile_ff   <= rsp_tile_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.piece_col  = rsp_col_ff;
   assign rsp_chan.piece_row  = rsp_row_ff;
   assign rsp_chan.shape_code = rsp_shape_ff;
   assign rsp_chan.size_code  = rsp_size_ff;
   assign rsp_chan.first_tile = rsp_tile_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.last_piece = rsp_last_ff;

endmodule
